// ----- sv/sfnt_table_integrity_check_unit_macros.svh -----
// Assertion macros for the sfnt table integrity check unit
`ifndef SFNT_TABLE_INTEGRITY_CHECK_UNIT_MACROS_SVH
`define SFNT_TABLE_INTEGRITY_CHECK_UNIT_MACROS_SVH

// same-cycle implication, reset disables
`define STIC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset disables
`define STIC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/stic_pkg.sv -----
// Package: status codes, register indexes and defaults of the table check unit
`default_nettype none

package stic_pkg;

	localparam int unsigned DefaultCountWidth = 16;

	localparam int unsigned PaddrWidth = 4;

	typedef enum logic [2:0] {
		STATUS_OK         = 3'd0,
		STATUS_SHORT_HEAD = 3'd1,
		STATUS_MISALIGNED = 3'd2,
		STATUS_BAD_PAD    = 3'd3,
		STATUS_MISMATCH   = 3'd4,
		STATUS_SKIPPED    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		REG_REQUIRE_ALIGNMENT    = 2'd0,
		REG_REQUIRE_ZERO_PADDING = 2'd1,
		REG_VERIFY_CHECKSUMS     = 2'd2
	} reg_index_t;

	localparam logic [3:0] HeadSkipFirst = 4'd8;
	localparam logic [3:0] HeadMinLength = 4'd12;
	localparam logic [1:0] PadPosMax     = 2'd3;

endpackage

`default_nettype wire

// ----- sv/sfnt_table_integrity_check_unit.sv -----
// Top level: sfnt table checksum, padding and alignment check, one byte a cycle unless stalled
//
// Input channel (item_valid / item_stall): one byte of a font table per word,
// table data first, then its alignment padding, last_item on the final word.
// Output channel (result_valid / result_stall): one result word for each input
// word with last_item set, carrying the table status and the font counters.
// The result of a last_item word is registered when the word is accepted.
// Throughput: one input word per cycle while item_stall is low; the per-byte sum
// and checks settle in one pass of logic between the table state registers.
// A two-deep result buffer (output register plus skid register) lets input
// words flow while a result is stalled; item_stall rises only when both hold
// a result, and falls the cycle after the output register is taken.
// The user writes configuration over the APB port only while the block is idle;
// the block does not enforce it. Reset (arst_n low) sets all three check enables,
// clears the table and font state and counters, and empties the result buffer.
`default_nettype none

module sfnt_table_integrity_check_unit
	import stic_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = DefaultCountWidth
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PaddrWidth-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output      logic [31:0]           prdata,
	output      logic                  pready,
	input  wire logic                  item_valid,
	output      logic                  item_stall,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  is_padding,
	input  wire logic                  empty_table,
	input  wire logic                  last_item,
	input  wire logic                  font_start,
	input  wire logic                  head_table,
	input  wire logic [1:0]            offset_low_bits,
	input  wire logic [31:0]           expected_checksum,
	output      logic                  result_valid,
	input  wire logic                  result_stall,
	output      logic [2:0]            status,
	output      logic [31:0]           actual_checksum,
	output      logic [7:0]            bad_padding_value,
	output      logic [1:0]            bad_padding_index,
	output      logic [15:0]           aligned_table_count,
	output      logic [15:0]           verified_table_count,
	output      logic [47:0]           payload_bytes,
	output      logic [17:0]           padding_bytes
);

	typedef struct packed {
		status_t     status;
		logic [31:0] checksum;
		logic [7:0]  pad_value;
		logic [1:0]  pad_index;
		logic [15:0] aligned;
		logic [15:0] verified;
		logic [47:0] payload;
		logic [17:0] padding;
	} result_t;

	logic require_alignment_q;
	logic require_zero_padding_q;
	logic verify_checksums_q;

	logic [31:0]            byte_pos_q;
	logic [31:0]            run_sum_q;
	logic [1:0]             pad_pos_q;
	logic                   pad_fault_q;
	logic [7:0]             fault_value_q;
	logic [1:0]             fault_index_q;
	logic                   font_failed_q;
	logic [COUNT_WIDTH-1:0] aligned_cnt_q;
	logic [COUNT_WIDTH-1:0] verified_cnt_q;
	logic [47:0]            payload_cnt_q;
	logic [17:0]            padding_cnt_q;

	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;

	logic                   item_acc;
	logic                   out_take;
	logic [31:0]            bp_e;
	logic [31:0]            sum_e;
	logic [1:0]             pp_e;
	logic                   pf_e;
	logic [7:0]             fv_e;
	logic [1:0]             fi_e;
	logic                   ff_e;
	logic [COUNT_WIDTH-1:0] al_e;
	logic [COUNT_WIDTH-1:0] vc_e;
	logic [47:0]            pay_e;
	logic [17:0]            padc_e;
	logic [31:0]            bp_n;
	logic [31:0]            sum_n;
	logic [1:0]             pp_n;
	logic                   pf_n;
	logic [7:0]             fv_n;
	logic [1:0]             fi_n;
	logic [31:0]            term;
	logic                   skip_byte;
	logic                   short_head;
	logic                   misaligned;
	logic                   counts_ok;
	logic                   pad_fail;
	logic                   sum_fail;
	logic [48:0]            pay_sum;
	logic [18:0]            padc_sum;
	logic [COUNT_WIDTH-1:0] al_n;
	logic [COUNT_WIDTH-1:0] vc_n;
	logic [47:0]            pay_n;
	logic [17:0]            padc_n;
	logic                   ff_n;
	status_t                st;
	result_t                res;

	assign pready = 1'b1;

	always_comb begin
		case (reg_index_t'(paddr[3:2]))
			REG_REQUIRE_ALIGNMENT:    prdata = {31'd0, require_alignment_q};
			REG_REQUIRE_ZERO_PADDING: prdata = {31'd0, require_zero_padding_q};
			REG_VERIFY_CHECKSUMS:     prdata = {31'd0, verify_checksums_q};
			default:                  prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			require_alignment_q    <= 1'b1;
			require_zero_padding_q <= 1'b1;
			verify_checksums_q     <= 1'b1;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_index_t'(paddr[3:2]))
				REG_REQUIRE_ALIGNMENT:    require_alignment_q <= pwdata[0];
				REG_REQUIRE_ZERO_PADDING: require_zero_padding_q <= pwdata[0];
				REG_VERIFY_CHECKSUMS:     verify_checksums_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	assign item_stall = skid_valid_q;
	assign item_acc   = item_valid && !item_stall;
	assign out_take   = out_valid_q && !result_stall;

	always_comb begin
		bp_e   = font_start ? 32'd0 : byte_pos_q;
		sum_e  = font_start ? 32'd0 : run_sum_q;
		pp_e   = font_start ? 2'd0 : pad_pos_q;
		pf_e   = font_start ? 1'b0 : pad_fault_q;
		fv_e   = font_start ? 8'd0 : fault_value_q;
		fi_e   = font_start ? 2'd0 : fault_index_q;
		ff_e   = font_start ? 1'b0 : font_failed_q;
		al_e   = font_start ? '0 : aligned_cnt_q;
		vc_e   = font_start ? '0 : verified_cnt_q;
		pay_e  = font_start ? 48'd0 : payload_cnt_q;
		padc_e = font_start ? 18'd0 : padding_cnt_q;

		case (bp_e[1:0])
			2'd0:    term = {data_byte, 24'd0};
			2'd1:    term = {8'd0, data_byte, 16'd0};
			2'd2:    term = {16'd0, data_byte, 8'd0};
			default: term = {24'd0, data_byte};
		endcase
		skip_byte = head_table && bp_e >= 32'(HeadSkipFirst) && bp_e < 32'(HeadMinLength);

		bp_n  = bp_e;
		sum_n = sum_e;
		pp_n  = pp_e;
		pf_n  = pf_e;
		fv_n  = fv_e;
		fi_n  = fi_e;
		if (!empty_table) begin
			if (is_padding) begin
				if (data_byte != 8'd0 && !pf_e) begin
					pf_n = 1'b1;
					fv_n = data_byte;
					fi_n = pp_e;
				end
				if (pp_e != PadPosMax) pp_n = pp_e + 2'd1;
			end else begin
				if (!skip_byte) sum_n = sum_e + term;
				if (bp_e != 32'hFFFF_FFFF) bp_n = bp_e + 32'd1;
			end
		end

		short_head = verify_checksums_q && head_table && bp_n < 32'(HeadMinLength);
		misaligned = require_alignment_q && offset_low_bits != 2'd0;
		counts_ok  = !ff_e && !short_head && !misaligned;
		pad_fail   = require_zero_padding_q && pf_n;
		sum_fail   = verify_checksums_q && sum_n != expected_checksum;

		pay_sum  = {1'b0, pay_e} + 49'(bp_n);
		padc_sum = {1'b0, padc_e} + 19'(pp_n);

		al_n   = al_e;
		vc_n   = vc_e;
		pay_n  = pay_e;
		padc_n = padc_e;
		if (counts_ok) begin
			if (offset_low_bits == 2'd0 && al_e != '1) al_n = al_e + 1'b1;
			pay_n = pay_sum[48] ? '1 : pay_sum[47:0];
			if (!pad_fail) begin
				if (require_zero_padding_q) padc_n = padc_sum[18] ? '1 : padc_sum[17:0];
				if (verify_checksums_q && !sum_fail && vc_e != '1) vc_n = vc_e + 1'b1;
			end
		end

		if (ff_e)            st = STATUS_SKIPPED;
		else if (short_head) st = STATUS_SHORT_HEAD;
		else if (misaligned) st = STATUS_MISALIGNED;
		else if (pad_fail)   st = STATUS_BAD_PAD;
		else if (sum_fail)   st = STATUS_MISMATCH;
		else                 st = STATUS_OK;

		ff_n = ff_e || (st != STATUS_OK);

		res.status    = st;
		res.checksum  = sum_n;
		res.pad_value = fv_n;
		res.pad_index = fi_n;
		res.aligned   = 16'(al_n);
		res.verified  = 16'(vc_n);
		res.payload   = pay_n;
		res.padding   = padc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q     <= 32'd0;
			run_sum_q      <= 32'd0;
			pad_pos_q      <= 2'd0;
			pad_fault_q    <= 1'b0;
			fault_value_q  <= 8'd0;
			fault_index_q  <= 2'd0;
			font_failed_q  <= 1'b0;
			aligned_cnt_q  <= '0;
			verified_cnt_q <= '0;
			payload_cnt_q  <= 48'd0;
			padding_cnt_q  <= 18'd0;
		end else if (item_acc) begin
			if (last_item) begin
				byte_pos_q     <= 32'd0;
				run_sum_q      <= 32'd0;
				pad_pos_q      <= 2'd0;
				pad_fault_q    <= 1'b0;
				fault_value_q  <= 8'd0;
				fault_index_q  <= 2'd0;
				font_failed_q  <= ff_n;
				aligned_cnt_q  <= al_n;
				verified_cnt_q <= vc_n;
				payload_cnt_q  <= pay_n;
				padding_cnt_q  <= padc_n;
			end else begin
				byte_pos_q     <= bp_n;
				run_sum_q      <= sum_n;
				pad_pos_q      <= pp_n;
				pad_fault_q    <= pf_n;
				fault_value_q  <= fv_n;
				fault_index_q  <= fi_n;
				font_failed_q  <= ff_e;
				aligned_cnt_q  <= al_e;
				verified_cnt_q <= vc_e;
				payload_cnt_q  <= pay_e;
				padding_cnt_q  <= padc_e;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (item_acc && last_item) begin
			if (out_valid_q && !out_take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) out_q <= skid_q;
		end else if (item_acc && last_item) begin
			if (out_valid_q && !out_take) skid_q <= res;
			else out_q <= res;
		end
	end

	assign result_valid         = out_valid_q;
	assign status               = out_q.status;
	assign actual_checksum      = out_q.checksum;
	assign bad_padding_value    = out_q.pad_value;
	assign bad_padding_index    = out_q.pad_index;
	assign aligned_table_count  = out_q.aligned;
	assign verified_table_count = out_q.verified;
	assign payload_bytes        = out_q.payload;
	assign padding_bytes        = out_q.padding;

endmodule

`default_nettype wire

// ----- sv/stic_checker.sv -----
// Port checker for the sfnt table integrity check unit and its bind
`default_nettype none

`include "sfnt_table_integrity_check_unit_macros.svh"

module stic_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_valid,
	input wire logic        item_stall,
	input wire logic        last_item,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [2:0]  status,
	input wire logic [31:0] actual_checksum
);

	`STIC_ASSERT_NEXT(a_out_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(status) && $stable(actual_checksum), "stalled result word changed")

	`STIC_ASSERT_NOW(a_stall_needs_result, clk, arst_n, item_stall, result_valid, "input stalled with no result held")

	`STIC_ASSERT_NEXT(a_last_gives_result, clk, arst_n, item_valid && !item_stall && last_item && !result_valid, result_valid, "last word gave no result")

	`STIC_ASSERT_NEXT(a_drain, clk, arst_n, result_valid && !result_stall && !item_stall && !(item_valid && last_item), !result_valid, "result word repeated")

endmodule

bind sfnt_table_integrity_check_unit stic_checker u_stic_checker (.*);

`default_nettype wire
